>>> design/hbsd_pkg.sv
// shared types, constants and handshake structs of the bit-serial code-tree decoder
package hbsd_pkg;

  localparam int MAX_NODES    = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOLS      = 128;

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int USED_W     = NODE_W + 1;
  localparam int SYM_W      = 7;
  localparam int CODE_W     = 32;
  localparam int CODE_IDX_W = $clog2(CODE_W);
  localparam int LEN_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int CMP_W      = (USED_W > LEN_W) ? USED_W : LEN_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic              op;
    logic [SYM_W-1:0]  symbol_in;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              data_bit;
  } in_t;

  typedef struct packed {
    logic                symbol_valid;
    logic [SYM_W-1:0]    symbol_out;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              leaf;
    logic [SYM_W-1:0]  sym;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_L_START,
    S_L_WALK,
    S_L_FILL,
    S_D_START,
    S_D_STEP,
    S_D_LEAF,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RD_ROOT,
    RD_WALK,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LEAF,
    WR_BRANCH,
    WR_FILL
  } wr_kind_t;

  typedef enum logic [2:0] {
    RES_LOAD_OK,
    RES_REJECT,
    RES_MISS,
    RES_SYM,
    RES_ADV
  } res_kind_t;

  typedef struct packed {
    logic      capture;
    logic      walk_init;
    logic      walk_advance;
    logic      rd_en;
    rd_sel_t   rd_sel;
    wr_kind_t  wr_kind;
    logic      res_en;
    res_kind_t res_kind;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_op;
    logic load_bad;
    logic at_end;
    logic child_missing;
    logic no_room;
    logic leaf_hit;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/huffman_bit_serial_decoder.sv
// top level of the bit-serial code-tree decoder: controller plus datapath
// Bit-serial prefix-code decoder. Each input beat is either a code load (op = 0),
// which walks the code from the root, first bit first, adding missing child nodes
// and marking the last node as a leaf that holds symbol_in, or a decode step
// (op = 1), which moves the walk one node along data_bit and returns the symbol
// when a leaf is reached. Every input beat gives exactly one output beat.
// Only one beat is in progress at a time: a new beat is accepted only after the
// result of the previous one has been moved into the output register. The pace is
// set by the single-port node table with its registered read: each tree level
// costs one table access, and a load writes one table entry per new node plus one
// for the link or leaf mark on the existing path. A result that is still waiting
// in the output register holds the block only when the following result is ready
// to go out. Errors are reported rather than left undefined: a decode step into an
// absent child gives status 1 and restarts at the root, and a load with a bad
// length, an out-of-range symbol or too few free nodes gives status 2 and changes
// nothing. No clearing pass is needed after reset: only the root entry carries a
// valid flag, and every other entry is written in full when it is allocated.
module huffman_bit_serial_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hbsd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hbsd_pkg::out_t out_data
);

  // command and status links between the sequencer and the datapath
  hbsd_pkg::ctrl_cmd_t cmd;
  hbsd_pkg::dp_stat_t  stat;

  // sequencer: accepts a beat only when idle, then steps through the walk
  hbsd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // node table, walk pointer, allocation counter and output register
  hbsd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

>>> design/hbsd_controller.sv
// sequencing state machine for code loads and decode steps
module hbsd_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hbsd_pkg::dp_stat_t stat,
  output hbsd_pkg::ctrl_cmd_t cmd
);

  hbsd_pkg::state_t state;
  hbsd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbsd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hbsd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (stat.in_op == hbsd_pkg::OP_DECODE) ? hbsd_pkg::S_D_START
                                                           : hbsd_pkg::S_L_START;
        end
      end
      hbsd_pkg::S_L_START: begin
        state_next = stat.load_bad ? hbsd_pkg::S_RESULT : hbsd_pkg::S_L_WALK;
      end
      hbsd_pkg::S_L_WALK: begin
        if (stat.at_end) begin
          state_next = hbsd_pkg::S_RESULT;
        end else if (stat.child_missing) begin
          state_next = stat.no_room ? hbsd_pkg::S_RESULT : hbsd_pkg::S_L_FILL;
        end
      end
      hbsd_pkg::S_L_FILL: begin
        if (stat.at_end) begin
          state_next = hbsd_pkg::S_RESULT;
        end
      end
      hbsd_pkg::S_D_START: begin
        state_next = hbsd_pkg::S_D_STEP;
      end
      hbsd_pkg::S_D_STEP: begin
        state_next = stat.child_missing ? hbsd_pkg::S_RESULT : hbsd_pkg::S_D_LEAF;
      end
      hbsd_pkg::S_D_LEAF: begin
        state_next = hbsd_pkg::S_RESULT;
      end
      hbsd_pkg::S_RESULT: begin
        if (stat.out_free) begin
          state_next = hbsd_pkg::S_IDLE;
        end
      end
      default: state_next = hbsd_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      hbsd_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      hbsd_pkg::S_L_START: begin
        if (stat.load_bad) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = hbsd_pkg::RES_REJECT;
        end else begin
          cmd.walk_init = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = hbsd_pkg::RD_ROOT;
        end
      end
      hbsd_pkg::S_L_WALK: begin
        if (stat.at_end) begin
          cmd.wr_kind  = hbsd_pkg::WR_LEAF;
          cmd.res_en   = 1'b1;
          cmd.res_kind = hbsd_pkg::RES_LOAD_OK;
        end else if (stat.child_missing) begin
          if (stat.no_room) begin
            cmd.res_en   = 1'b1;
            cmd.res_kind = hbsd_pkg::RES_REJECT;
          end else begin
            cmd.wr_kind = hbsd_pkg::WR_BRANCH;
          end
        end else begin
          cmd.walk_advance = 1'b1;
          cmd.rd_en        = 1'b1;
          cmd.rd_sel       = hbsd_pkg::RD_NEXT;
        end
      end
      hbsd_pkg::S_L_FILL: begin
        cmd.wr_kind = hbsd_pkg::WR_FILL;
        if (stat.at_end) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = hbsd_pkg::RES_LOAD_OK;
        end
      end
      hbsd_pkg::S_D_START: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = hbsd_pkg::RD_WALK;
      end
      hbsd_pkg::S_D_STEP: begin
        if (stat.child_missing) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = hbsd_pkg::RES_MISS;
        end else begin
          cmd.walk_advance = 1'b1;
          cmd.rd_en        = 1'b1;
          cmd.rd_sel       = hbsd_pkg::RD_NEXT;
        end
      end
      hbsd_pkg::S_D_LEAF: begin
        cmd.res_en   = 1'b1;
        cmd.res_kind = stat.leaf_hit ? hbsd_pkg::RES_SYM : hbsd_pkg::RES_ADV;
      end
      hbsd_pkg::S_RESULT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> design/hbsd_datapath.sv
// node table, walk registers, allocation counter and result registers
module hbsd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  hbsd_pkg::in_t       in_item,
  input  hbsd_pkg::ctrl_cmd_t cmd,
  output hbsd_pkg::dp_stat_t  stat,
  input  logic                out_ready,
  output logic                out_valid,
  output hbsd_pkg::out_t      out_item
);

  // captured item
  logic                          op_q;
  logic [hbsd_pkg::SYM_W-1:0]    sym_q;
  logic [hbsd_pkg::CODE_W-1:0]   bits_q;
  logic [hbsd_pkg::LEN_W-1:0]    len_q;
  logic                          dbit_q;

  // walk and allocation state
  logic [hbsd_pkg::NODE_W-1:0]   cur;
  logic [hbsd_pkg::LEN_W-1:0]    step;
  logic [hbsd_pkg::NODE_W-1:0]   alloc;
  logic [hbsd_pkg::USED_W-1:0]   nodes_used;
  logic [hbsd_pkg::NODE_W-1:0]   walk_node;
  logic                          root_valid;

  // node table
  hbsd_pkg::node_t               mem [hbsd_pkg::MAX_NODES];
  hbsd_pkg::node_t               mem_q;
  logic                          root_empty_q;
  hbsd_pkg::node_t               rd_ent;
  logic [hbsd_pkg::NODE_W-1:0]   rd_addr;
  logic                          wr_en;
  logic [hbsd_pkg::NODE_W-1:0]   wr_addr;
  hbsd_pkg::node_t               wr_data;

  logic [hbsd_pkg::LEN_W-1:0]    pos;
  logic                          lbit;
  logic                          bit_sel;
  logic [hbsd_pkg::NODE_W-1:0]   nxt;
  logic [hbsd_pkg::CMP_W-1:0]    need;
  logic [hbsd_pkg::CMP_W-1:0]    free_cnt;
  logic [hbsd_pkg::NODE_W-1:0]   new_idx;

  hbsd_pkg::out_t                res_q;
  hbsd_pkg::out_t                res_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_item.op;
      sym_q  <= in_item.symbol_in;
      bits_q <= in_item.code_bits;
      len_q  <= in_item.code_length;
      dbit_q <= in_item.data_bit;
    end
  end

  assign rd_ent = root_empty_q ? '0 : mem_q;

  // code bit for the current step, first bit is the top valid one
  assign pos  = len_q - hbsd_pkg::LEN_W'(1) - step;
  assign lbit = (int'(pos) < hbsd_pkg::CODE_W) ? bits_q[pos[hbsd_pkg::CODE_IDX_W-1:0]] : 1'b0;

  assign bit_sel = (op_q == hbsd_pkg::OP_DECODE) ? dbit_q : lbit;
  assign nxt     = bit_sel ? rd_ent.right : rd_ent.left;
  assign new_idx = nodes_used[hbsd_pkg::NODE_W-1:0];

  assign need     = hbsd_pkg::CMP_W'(len_q - step);
  assign free_cnt = hbsd_pkg::CMP_W'(hbsd_pkg::MAX_NODES) - hbsd_pkg::CMP_W'(nodes_used);

  always_comb begin
    stat.in_op         = in_item.op;
    stat.load_bad      = (len_q == '0) || (int'(len_q) > hbsd_pkg::MAX_CODE_LEN) ||
                         (int'(sym_q) >= hbsd_pkg::SYMBOLS);
    stat.at_end        = (step == len_q);
    stat.child_missing = (nxt == '0);
    stat.no_room       = (need > free_cnt);
    stat.leaf_hit      = rd_ent.leaf;
    stat.out_free      = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.rd_sel)
      hbsd_pkg::RD_ROOT: rd_addr = '0;
      hbsd_pkg::RD_WALK: rd_addr = walk_node;
      hbsd_pkg::RD_NEXT: rd_addr = nxt;
      default:           rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = rd_ent;
    unique case (cmd.wr_kind)
      hbsd_pkg::WR_NONE: begin
        wr_en = 1'b0;
      end
      hbsd_pkg::WR_LEAF: begin
        wr_en        = 1'b1;
        wr_data.leaf = 1'b1;
        wr_data.sym  = sym_q;
      end
      hbsd_pkg::WR_BRANCH: begin
        wr_en = 1'b1;
        if (lbit) begin
          wr_data.right = new_idx;
        end else begin
          wr_data.left = new_idx;
        end
      end
      hbsd_pkg::WR_FILL: begin
        // fresh node: fully written, so never read stale
        wr_en   = 1'b1;
        wr_addr = alloc;
        wr_data = '0;
        if (step == len_q) begin
          wr_data.leaf = 1'b1;
          wr_data.sym  = sym_q;
        end else if (lbit) begin
          wr_data.right = alloc + hbsd_pkg::NODE_W'(1);
        end else begin
          wr_data.left = alloc + hbsd_pkg::NODE_W'(1);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q        <= mem[rd_addr];
      root_empty_q <= (rd_addr == '0) && !root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (wr_en && (wr_addr == '0)) begin
      root_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      cur <= '0;
    end else if (cmd.walk_advance) begin
      cur <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      step <= '0;
    end else if (cmd.walk_advance || (cmd.wr_kind == hbsd_pkg::WR_BRANCH) ||
                 (cmd.wr_kind == hbsd_pkg::WR_FILL)) begin
      step <= step + hbsd_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_kind == hbsd_pkg::WR_BRANCH) begin
      alloc <= new_idx;
    end else if (cmd.wr_kind == hbsd_pkg::WR_FILL) begin
      alloc <= alloc + hbsd_pkg::NODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used <= hbsd_pkg::USED_W'(1);
    end else if (cmd.wr_kind == hbsd_pkg::WR_FILL) begin
      nodes_used <= nodes_used + hbsd_pkg::USED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_node <= '0;
    end else if (cmd.res_en) begin
      case (cmd.res_kind) inside
        hbsd_pkg::RES_MISS, hbsd_pkg::RES_SYM: walk_node <= '0;
        hbsd_pkg::RES_ADV:                     walk_node <= cur;
        default:                               walk_node <= walk_node;
      endcase
    end
  end

  always_comb begin
    res_next = '0;
    case (cmd.res_kind)
      hbsd_pkg::RES_REJECT: res_next.status = hbsd_pkg::ST_REJECT;
      hbsd_pkg::RES_MISS:   res_next.status = hbsd_pkg::ST_MISS;
      hbsd_pkg::RES_SYM: begin
        res_next.symbol_valid = 1'b1;
        res_next.symbol_out   = rd_ent.sym;
      end
      default:              res_next.status = hbsd_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      res_q <= res_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item <= res_q;
    end
  end

endmodule

>>> design/hbsd_checker.sv
// port-level checks of the decoder and their binding to the top level
module hbsd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input hbsd_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input hbsd_pkg::out_t out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // no result can appear in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // after reset the block is idle and empty
  a_reset_idle: assert property (@(posedge clk)
    $fell(rst) |-> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind huffman_bit_serial_decoder hbsd_checker u_chk (.*);

>>> test/tb_huffman_bit_serial_decoder.sv
// self-checking testbench for the bit-serial code-tree decoder
module tb_huffman_bit_serial_decoder;

  // watchdog: cycles in a row with no beat on either side
  localparam int STALL_LIMIT   = 2000;
  // a load walks up to 32 levels
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_BEATS   = 250;
  localparam int REPORT_MAX    = 10;

  // tree mirror plus the queue of result beats still owed by the block
  class symbol_scoreboard;
    logic [hbsd_pkg::NODE_W-1:0] kid [hbsd_pkg::MAX_NODES][2];
    logic                        leaf_flag [hbsd_pkg::MAX_NODES];
    logic [hbsd_pkg::SYM_W-1:0]  leaf_sym [hbsd_pkg::MAX_NODES];
    int unsigned                 nodes_used;
    logic [hbsd_pkg::NODE_W-1:0] walk;
    hbsd_pkg::out_t              due_results[$];
    int unsigned                 mismatches;

    function new();
      foreach (leaf_flag[i]) begin
        kid[i][0]    = '0;
        kid[i][1]    = '0;
        leaf_flag[i] = 1'b0;
        leaf_sym[i]  = '0;
      end
      nodes_used = 1;
      walk       = '0;
      mismatches = 0;
    endfunction

    // all-or-nothing insertion of one code, first pass only counts new nodes
    function logic [hbsd_pkg::STATUS_W-1:0] load_code(logic [hbsd_pkg::SYM_W-1:0] sym,
                                                      logic [hbsd_pkg::CODE_W-1:0] bits,
                                                      logic [hbsd_pkg::LEN_W-1:0] len);
      int unsigned need, cur, i;
      logic        br;
      if (len == 0 || len > hbsd_pkg::MAX_CODE_LEN || sym >= hbsd_pkg::SYMBOLS)
        return hbsd_pkg::ST_REJECT;
      need = 0;
      cur  = 0;
      for (i = 0; i < len; i++) begin
        br = bits[len - 1 - i];
        if (kid[cur][br] == '0) begin
          need = len - i;
          break;
        end
        cur = kid[cur][br];
      end
      if (need > hbsd_pkg::MAX_NODES - nodes_used) return hbsd_pkg::ST_REJECT;
      cur = 0;
      for (i = 0; i < len; i++) begin
        br = bits[len - 1 - i];
        if (kid[cur][br] == '0) begin
          kid[nodes_used][0]    = '0;
          kid[nodes_used][1]    = '0;
          leaf_flag[nodes_used] = 1'b0;
          leaf_sym[nodes_used]  = '0;
          kid[cur][br]          = nodes_used[hbsd_pkg::NODE_W-1:0];
          nodes_used++;
        end
        cur = kid[cur][br];
      end
      // a node on the path may already be a leaf, it simply stays one
      leaf_flag[cur] = 1'b1;
      leaf_sym[cur]  = sym;
      return hbsd_pkg::ST_OK;
    endfunction

    function void note_beat(hbsd_pkg::in_t b);
      hbsd_pkg::out_t              res;
      logic [hbsd_pkg::NODE_W-1:0] nxt;
      res = '0;
      if (b.op == hbsd_pkg::OP_LOAD) begin
        res.status = load_code(b.symbol_in, b.code_bits, b.code_length);
      end else begin
        nxt = kid[walk][b.data_bit];
        if (nxt == '0) begin
          res.status = hbsd_pkg::ST_MISS;
          walk       = '0;
        end else if (leaf_flag[nxt]) begin
          res.symbol_valid = 1'b1;
          res.symbol_out   = leaf_sym[nxt];
          walk             = '0;
        end else begin
          walk = nxt;
        end
      end
      due_results.push_back(res);
    endfunction

    function void flag(string what, hbsd_pkg::out_t want, hbsd_pkg::out_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch (%s): expected valid=%0b sym=%0d status=%0d, %s",
                 what, want.symbol_valid, want.symbol_out, want.status,
                 $sformatf("got valid=%0b sym=%0d status=%0d",
                           got.symbol_valid, got.symbol_out, got.status));
    endfunction

    function void check_beat(hbsd_pkg::out_t got);
      hbsd_pkg::out_t want;
      if (due_results.size() == 0) begin
        flag("result beat with nothing pending", '0, got);
        return;
      end
      want = due_results.pop_front();
      if (got.symbol_valid !== want.symbol_valid) flag("symbol_valid", want, got);
      if (got.symbol_out !== want.symbol_out) flag("symbol_out", want, got);
      if (got.status !== want.status) flag("status", want, got);
    endfunction
  endclass

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  hbsd_pkg::in_t   in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  hbsd_pkg::out_t  out_data;

  symbol_scoreboard sb = new();

  // idle percentages, changed per phase
  int src_idle_pct  = 8;
  int sink_idle_pct = 82;
  int beats_sent    = 0;
  int quiet_cycles  = 0;

  huffman_bit_serial_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure, one draw per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // monitor: results are checked before the new input beat is noted, since a
  // beat accepted at this edge cannot have its result out at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_beat(out_data);
      if (in_valid && in_ready) sb.note_beat(in_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_huffman_bit_serial_decoder: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // hold one beat on the input until it is taken, with random gaps before it;
  // valid is only lowered when a gap is actually inserted
  task automatic push_beat(input hbsd_pkg::in_t b);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // fields the operation ignores still carry random values
  task automatic send_load(input logic [hbsd_pkg::SYM_W-1:0] sym,
                           input logic [hbsd_pkg::CODE_W-1:0] bits,
                           input logic [hbsd_pkg::LEN_W-1:0] len);
    hbsd_pkg::in_t b;
    b.op          = hbsd_pkg::OP_LOAD;
    b.symbol_in   = sym;
    b.code_bits   = bits;
    b.code_length = len;
    b.data_bit    = 1'($urandom_range(1));
    push_beat(b);
  endtask

  task automatic send_decode(input logic bit_in);
    hbsd_pkg::in_t b;
    b.op          = hbsd_pkg::OP_DECODE;
    b.symbol_in   = 7'($urandom_range(127));
    b.code_bits   = $urandom;
    b.code_length = 6'($urandom_range(63));
    b.data_bit    = bit_in;
    push_beat(b);
  endtask

  // compressed bits, most significant of the n first
  task automatic send_bits(input logic [hbsd_pkg::CODE_W-1:0] bits, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) send_decode(bits[i]);
  endtask

  // mostly short codes, some long ones to fill the table, some bad lengths
  task automatic send_random_load();
    int                         pick;
    logic [hbsd_pkg::LEN_W-1:0] len;
    pick = $urandom_range(99);
    if (pick < 65)      len = 6'($urandom_range(6, 1));
    else if (pick < 88) len = 6'($urandom_range(hbsd_pkg::MAX_CODE_LEN, 7));
    else if (pick < 94) len = '0;
    else                len = 6'($urandom_range(63, hbsd_pkg::MAX_CODE_LEN + 1));
    send_load(7'($urandom_range(127)), $urandom, len);
  endtask

  // follow existing branches of the mirrored tree from the current walk node
  // until a leaf, so most sequences complete a symbol; some are cut short
  task automatic send_symbol_walk();
    logic [hbsd_pkg::NODE_W-1:0] node, nxt;
    logic                        have0, have1, br;
    int                          steps, cut;
    bit                          done;
    node  = sb.walk;
    steps = 0;
    done  = 0;
    cut   = ($urandom_range(9) == 0) ? $urandom_range(hbsd_pkg::MAX_CODE_LEN, 1)
                                     : hbsd_pkg::MAX_CODE_LEN + 1;
    while (!done && steps < cut) begin
      have0 = (sb.kid[node][0] != '0);
      have1 = (sb.kid[node][1] != '0);
      if (have0 == have1) br = 1'($urandom_range(1));
      else                br = have1;
      send_decode(br);
      steps++;
      nxt = sb.kid[node][br];
      if (nxt == '0 || sb.leaf_flag[nxt]) done = 1;
      else node = nxt;
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int beats);
    int goal, pick;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    goal          = beats_sent + beats;
    while (beats_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 18)      send_random_load();
      else if (pick < 28) send_decode(1'($urandom_range(1)));
      else                send_symbol_walk();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty tree: the very first bit has no child to go to
    send_decode(1'b0);
    // bad lengths: zero, one past the maximum, and the largest the field holds
    send_load(7'd3, 32'h0000_0000, 6'd0);
    send_load(7'd3, 32'h0000_0001, 6'd33);
    send_load(7'd3, 32'hFFFF_FFFF, 6'd63);
    // longest code, all ones, top symbol
    send_load(7'd127, 32'hFFFF_FFFF, 6'd32);
    // code 010 with junk above the valid bits, symbol zero
    send_load(7'd0, 32'hFFFF_FFFA, 6'd3);
    send_load(7'd1, 32'h0000_0000, 6'd3);
    send_bits(32'b010, 3);
    send_bits(32'b000, 3);
    // 011 misses at the third level and restarts at the root
    send_bits(32'b011, 3);
    // code that runs through the leaf 010, which must still stop the walk
    send_load(7'd2, 32'b0100, 6'd4);
    send_bits(32'b010, 3);
    // reloading 010 replaces its symbol
    send_load(7'd126, 32'b010, 6'd3);
    send_bits(32'b010, 3);

    run_phase(8, 82, PHASE_BEATS);
    run_phase(82, 8, PHASE_BEATS);
    run_phase(0, 0, PHASE_BEATS);

    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    // let any stray result beat show up before judging
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.due_results.size() == 0)
      $display("tb_huffman_bit_serial_decoder: PASS");
    else
      $display("tb_huffman_bit_serial_decoder: FAIL");
    $finish;
  end

endmodule
